### rtl/kmp_substring_search_unit_assert.svh
// ----------------------------------------------------------------------------
// kmp substring search unit assertion macros
// shared property templates for the port-level checker
// ----------------------------------------------------------------------------
`ifndef KMP_SUBSTRING_SEARCH_UNIT_ASSERT_SVH
`define KMP_SUBSTRING_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication
`define KSS_ASSERT_SAME(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kss assertion failed");

// next-cycle implication
`define KSS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kss assertion failed");

`endif

### rtl/kss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_pkg
// shared constants and types of the kmp substring search unit
// ----------------------------------------------------------------------------
package kss_pkg;

	localparam int MAX_PATTERN = 64;
	localparam int POS_WIDTH   = 16;
	localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
	localparam int DATA_W      = 8;
	localparam int MATCH_POS_W = 16;
	localparam int PROGRESS_W  = 7;
	localparam int OUT_W       = 1 + MATCH_POS_W + PROGRESS_W;

	// op codes of an input beat
	localparam logic OP_PATTERN = 1'b0;
	localparam logic OP_TEXT    = 1'b1;

	// walk request: start prefix and the byte to extend it with
	typedef struct packed {
		logic              start;
		logic [IDX_W-1:0]  k;
		logic [DATA_W-1:0] b;
	} walk_req_t;

	// walk response: final prefix length
	typedef struct packed {
		logic             done;
		logic [LEN_W-1:0] k;
	} walk_rsp_t;

endpackage

### rtl/kss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module kss_ram #(
	parameter  int DEPTH = 64,
	parameter  int WIDTH = 8,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/kss_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_walk
// failure-link walker shared by table build and text search
// ----------------------------------------------------------------------------
module kss_walk (
	input  logic                             clk,
	input  logic                             arst_n,
	input  kss_pkg::walk_req_t               req,
	output kss_pkg::walk_rsp_t               rsp,
	output logic [kss_pkg::IDX_W-1:0]        pat_raddr,
	output logic [kss_pkg::IDX_W-1:0]        fail_raddr,
	input  logic [kss_pkg::DATA_W-1:0]       pat_rdata,
	input  logic [kss_pkg::IDX_W-1:0]        fail_rdata
);
	import kss_pkg::*;

	typedef enum logic [2:0] {
		W_IDLE = 3'b001,
		W_READ = 3'b010,
		W_CMP  = 3'b100
	} walk_state_t;

	walk_state_t       state_q;
	logic [IDX_W-1:0]  k_q;
	logic [DATA_W-1:0] b_q;
	logic              hit;
	logic              step;

	// pattern byte at k and link at k-1 (wraps at k = 0, then unused)
	assign pat_raddr  = k_q;
	assign fail_raddr = k_q - IDX_W'(1);

	assign hit  = (pat_rdata == b_q);
	assign step = (state_q == W_CMP) && !hit && (k_q != '0);

	assign rsp.done = (state_q == W_CMP) && !step;
	assign rsp.k    = LEN_W'(k_q) + LEN_W'(hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
		end else begin
			case (state_q)
				W_IDLE: begin
					if (req.start) state_q <= W_READ;
				end
				W_READ: begin
					state_q <= W_CMP;
				end
				W_CMP: begin
					state_q <= step ? W_READ : W_IDLE;
				end
				default: begin
					state_q <= W_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == W_IDLE && req.start) begin
			k_q <= req.k;
			b_q <= req.b;
		end else if (step) begin
			k_q <= fail_rdata;
		end
	end

endmodule

### rtl/kmp_substring_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_substring_search_unit
// knuth-morris-pratt search with an online failure table build
// ----------------------------------------------------------------------------
// input beats (s_*): tdata is the byte, tuser[0] picks pattern (0) or text (1),
// tuser[1] starts a new pattern or a new text. a new pattern also clears the
// text state. output beats (m_*) come only for text bytes and carry the found
// flag, the start of the first match and the current matched prefix length.
// every beat that needs a walk runs through one failure-link walker that reads
// the pattern and link memories: each walk step is a ram read, then a compare.
// a text byte follows failure links (amortized under one per byte) until it
// extends the prefix or reaches zero, and its result then goes into the output
// register; an empty pattern or a text byte after a match skips the walk.
// the first pattern byte skips the walk too; later pattern bytes walk the links.
// s_tready is high only while the sequencer is idle. the output register lets
// the next beat be taken while a result waits; if the receiver keeps stalling,
// the next text beat holds in the sequencer with s_tready low until the
// waiting result is taken.
// reset clears all control state; the pattern memories need no clearing.
// ----------------------------------------------------------------------------
module kmp_substring_search_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [kss_pkg::DATA_W-1:0]   s_tdata,  // data[7:0]
	input  logic [1:0]                   s_tuser,  // op[0], first[1]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [kss_pkg::OUT_W-1:0]    m_tdata   // found[0], match_pos[16:1], progress[23:17]
);
	import kss_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_EMIT = 3'b100
	} top_state_t;

	top_state_t           state_q;
	logic                 op_q;
	logic [LEN_W-1:0]     len_q;
	logic [IDX_W-1:0]     bp_q;
	logic [LEN_W-1:0]     mp_q;
	logic [POS_WIDTH-1:0] tc_q;
	logic                 found_q;
	logic [POS_WIDTH-1:0] start_q;
	logic [POS_WIDTH-1:0] pos_q;
	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_data_q;

	logic                 in_op;
	logic                 in_first;
	logic                 accept;
	logic                 clr_pat;
	logic                 clr_txt;
	logic [LEN_W-1:0]     len_eff;
	logic [IDX_W-1:0]     bp_eff;
	logic [LEN_W-1:0]     mp_eff;
	logic [POS_WIDTH-1:0] tc_eff;
	logic                 found_eff;
	logic [LEN_W-1:0]     q_start;
	logic                 pat_we;
	logic                 txt_go;
	logic                 walk_go;
	logic                 walk_end;
	logic                 emit;
	logic [POS_WIDTH:0]   pos_inc;

	logic                 fail_we;
	logic [IDX_W-1:0]     fail_waddr;
	logic [IDX_W-1:0]     fail_wdata;
	logic [IDX_W-1:0]     pat_raddr;
	logic [IDX_W-1:0]     fail_raddr;
	logic [DATA_W-1:0]    pat_rdata;
	logic [IDX_W-1:0]     fail_rdata;

	walk_req_t            req;
	walk_rsp_t            rsp;

	assign in_op    = s_tuser[0];
	assign in_first = s_tuser[1];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// a new pattern clears the text too
	assign clr_pat = accept && (in_op == OP_PATTERN) && in_first;
	assign clr_txt = accept && in_first;

	assign len_eff   = clr_pat ? '0 : len_q;
	assign bp_eff    = clr_pat ? '0 : bp_q;
	assign mp_eff    = clr_txt ? '0 : mp_q;
	assign tc_eff    = clr_txt ? '0 : tc_q;
	assign found_eff = clr_txt ? 1'b0 : found_q;

	// pattern bytes past capacity are dropped
	assign pat_we  = accept && (in_op == OP_PATTERN) && (len_eff != LEN_W'(MAX_PATTERN));
	// text bytes after a match leave the state alone
	assign txt_go  = accept && (in_op == OP_TEXT) && !found_eff;
	assign q_start = (mp_eff >= len_q) ? '0 : mp_eff;

	assign walk_go  = (pat_we && (len_eff != '0)) || (txt_go && (len_q != '0));
	assign walk_end = (state_q == S_WALK) && rsp.done;
	assign emit     = (state_q == S_EMIT) && (!out_valid_q || m_tready);

	assign req.start = walk_go;
	assign req.k     = (in_op == OP_PATTERN) ? bp_eff : IDX_W'(q_start);
	assign req.b     = s_tdata;

	// first link entry is zero, the rest come from the walk
	assign fail_we    = (pat_we && (len_eff == '0)) || (walk_end && (op_q == OP_PATTERN));
	assign fail_waddr = (state_q == S_WALK) ? IDX_W'(len_q) : IDX_W'(len_eff);
	assign fail_wdata = (state_q == S_WALK) ? IDX_W'(rsp.k) : '0;

	assign pos_inc = {1'b0, pos_q} + (POS_WIDTH + 1)'(1);

	kss_ram #(
		.DEPTH(MAX_PATTERN),
		.WIDTH(DATA_W)
	) u_pat_ram (
		.clk  (clk),
		.we   (pat_we),
		.waddr(IDX_W'(len_eff)),
		.wdata(s_tdata),
		.raddr(pat_raddr),
		.rdata(pat_rdata)
	);

	kss_ram #(
		.DEPTH(MAX_PATTERN),
		.WIDTH(IDX_W)
	) u_fail_ram (
		.clk  (clk),
		.we   (fail_we),
		.waddr(fail_waddr),
		.wdata(fail_wdata),
		.raddr(fail_raddr),
		.rdata(fail_rdata)
	);

	kss_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.pat_raddr (pat_raddr),
		.fail_raddr(fail_raddr),
		.pat_rdata (pat_rdata),
		.fail_rdata(fail_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (walk_go)              state_q <= S_WALK;
						else if (in_op == OP_TEXT) state_q <= S_EMIT;
					end
				end
				S_WALK: begin
					if (rsp.done) state_q <= (op_q == OP_TEXT) ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (emit) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= OP_PATTERN;
			len_q   <= '0;
			bp_q    <= '0;
			mp_q    <= '0;
			tc_q    <= '0;
			found_q <= 1'b0;
			start_q <= '0;
		end else begin
			if (accept) begin
				op_q <= in_op;
			end
			if (clr_txt) begin
				mp_q    <= '0;
				tc_q    <= '0;
				found_q <= 1'b0;
				start_q <= '0;
			end
			if (clr_pat) begin
				len_q <= '0;
				bp_q  <= '0;
			end
			if (pat_we && (len_eff == '0)) begin
				bp_q  <= '0;
				len_q <= LEN_W'(1);
			end
			if (txt_go) begin
				// position saturates at the top of its range
				if (tc_eff != '1) tc_q <= tc_eff + POS_WIDTH'(1);
				else              tc_q <= tc_eff;
				if (len_q == '0) mp_q <= '0;
			end
			if (walk_end) begin
				if (op_q == OP_PATTERN) begin
					bp_q  <= IDX_W'(rsp.k);
					len_q <= len_q + LEN_W'(1);
				end else begin
					mp_q <= rsp.k;
					if (rsp.k == len_q) begin
						found_q <= 1'b1;
						// start clamps to zero when it would go negative
						if (pos_inc >= (POS_WIDTH + 1)'(len_q))
							start_q <= POS_WIDTH'(pos_inc - (POS_WIDTH + 1)'(len_q));
						else
							start_q <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (txt_go) pos_q <= tc_eff;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= {PROGRESS_W'(mp_q),
				found_q ? MATCH_POS_W'(start_q) : MATCH_POS_W'(0),
				found_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

### rtl/kss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_checker
// port-level checks of the kmp substring search unit
// ----------------------------------------------------------------------------
`include "kmp_substring_search_unit_assert.svh"

module kss_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [kss_pkg::OUT_W-1:0] m_tdata
);
	import kss_pkg::*;

	// a stalled result beat holds
	`KSS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// no match reports position zero
	`KSS_ASSERT_SAME(a_pos_zero, clk, arst_n, m_tvalid && !m_tdata[0], m_tdata[MATCH_POS_W:1] == '0)

	// a match implies a nonempty matched prefix
	`KSS_ASSERT_SAME(a_found_prog, clk, arst_n, m_tvalid && m_tdata[0], m_tdata[OUT_W-1:MATCH_POS_W+1] != '0)

endmodule

bind kmp_substring_search_unit kss_checker u_kss_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// directed and random streaming tests of kmp_substring_search_unit
// ----------------------------------------------------------------------------
// pattern and text beats go in on the s_* side; an in-bench knuth-morris-pratt
// predictor works out the report of each text beat, and every beat taken on
// the m_* side is compared field by field with the oldest pending report.
// covers the empty pattern, failure-link walks, the sticky match, pattern
// growth mid-text, pattern overflow and a long receiver hold-off, with random
// gaps on both sides.
// ----------------------------------------------------------------------------
module tb;
	import kss_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int QUIET_LIMIT  = 2000;
	localparam int SETTLE_TICKS = 300;
	localparam int RANDOM_BEATS = 360;

	typedef struct packed {
		logic [PROGRESS_W-1:0]  progress;
		logic [MATCH_POS_W-1:0] match_pos;
		logic                   found;
	} scan_report_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;   // data[7:0]
	logic [1:0]        s_tuser;   // op[0], first[1]
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;   // found[0], match_pos[16:1], progress[23:17]

	kmp_substring_search_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#HALF_PERIOD;
		clk = 1'b0;
		#HALF_PERIOD;
	end

	// predictor state
	logic [DATA_W-1:0]    pat_mem  [MAX_PATTERN];
	logic [IDX_W-1:0]     link_mem [MAX_PATTERN];
	logic [LEN_W-1:0]     pat_len;
	logic [IDX_W-1:0]     build_k;
	logic [LEN_W-1:0]     scan_q;
	logic [POS_WIDTH-1:0] scan_pos;
	logic                 found_latch;
	logic [POS_WIDTH-1:0] found_at;

	scan_report_t scan_reports_q[$];
	int           mismatches;
	int           reports_checked;
	int           pattern_beats;
	int           text_beats;
	int           matches_seen;
	bit           sender_gaps_on;
	bit           sink_stalls_on;
	int           sink_hold;

	function automatic void clear_scan();
		scan_q      = '0;
		scan_pos    = '0;
		found_latch = 1'b0;
		found_at    = '0;
	endfunction

	// online failure-link build, one pattern byte at a time
	function automatic void learn_pattern_byte(input logic fst, input logic [DATA_W-1:0] b);
		int k;
		if (fst) begin
			pat_len = '0;
			build_k = '0;
			clear_scan();
		end
		if (pat_len >= MAX_PATTERN)
			return;
		pat_mem[pat_len] = b;
		if (pat_len == 0) begin
			link_mem[0] = '0;
			build_k     = '0;
		end else begin
			k = build_k;
			while (k > 0 && pat_mem[k] != b)
				k = link_mem[k-1];
			if (pat_mem[k] == b)
				k++;
			link_mem[pat_len] = IDX_W'(k);
			build_k           = IDX_W'(k);
		end
		pat_len = pat_len + 1'b1;
	endfunction

	function automatic scan_report_t scan_text_byte(input logic fst, input logic [DATA_W-1:0] b);
		scan_report_t rep;
		int q;
		int pos;
		if (fst)
			clear_scan();
		if (!found_latch) begin
			pos = scan_pos;
			if (scan_pos != {POS_WIDTH{1'b1}})
				scan_pos = scan_pos + 1'b1;
			if (pat_len == 0) begin
				scan_q = '0;
			end else begin
				q = scan_q;
				if (q >= pat_len)
					q = 0;
				while (q > 0 && pat_mem[q] != b)
					q = link_mem[q-1];
				if (pat_mem[q] == b)
					q++;
				scan_q = LEN_W'(q);
				if (q == pat_len) begin
					found_latch = 1'b1;
					found_at    = (pos + 1 >= q) ? POS_WIDTH'(pos + 1 - q) : '0;
				end
			end
		end
		rep.found     = found_latch;
		rep.match_pos = found_latch ? MATCH_POS_W'(found_at) : '0;
		rep.progress  = PROGRESS_W'(scan_q);
		return rep;
	endfunction

	// mostly short idles, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	task automatic send_beat(input logic op, input logic [DATA_W-1:0] b, input logic fst);
		int gap;
		gap = sender_gaps_on ? idle_len() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= {fst, op};
		do
			@(posedge clk);
		while (!s_tready);
		if (op == OP_PATTERN) begin
			learn_pattern_byte(fst, b);
			pattern_beats++;
		end else begin
			scan_reports_q.push_back(scan_text_byte(fst, b));
			text_beats++;
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (scan_reports_q.size() != 0)
			@(posedge clk);
	endtask

	// receiver: random stalls, plus a long hold-off when a test asks for one
	initial begin : sink_side
		int n;
		forever begin
			if (sink_hold > 0) begin
				n         = sink_hold;
				sink_hold = 0;
			end else begin
				n = sink_stalls_on ? idle_len() : 0;
			end
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin : report_check
		scan_report_t got;
		scan_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = scan_report_t'(m_tdata);
			if (scan_reports_q.size() == 0) begin
				$error("unexpected report beat 0x%06h", m_tdata);
				mismatches++;
			end else begin
				want = scan_reports_q.pop_front();
				reports_checked++;
				if (got.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, got.found);
					mismatches++;
				end
				if (got.match_pos !== want.match_pos) begin
					$error("match_pos: expected %0d, got %0d", want.match_pos, got.match_pos);
					mismatches++;
				end
				if (got.progress !== want.progress) begin
					$error("progress: expected %0d, got %0d", want.progress, got.progress);
					mismatches++;
				end
				if (want.found)
					matches_seen++;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no beat for %0d cycles", QUIET_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// empty pattern, extreme bytes, sticky match, growth mid-text, new pattern
	task automatic test_directed();
		sender_gaps_on = 1'b0;
		sink_stalls_on = 1'b0;
		// no pattern yet: never matches, position still moves
		send_beat(OP_TEXT, 8'h00, 1'b1);
		send_beat(OP_TEXT, 8'hFF, 1'b0);
		send_beat(OP_TEXT, 8'h41, 1'b0);
		send_beat(OP_PATTERN, 8'h00, 1'b1);
		send_beat(OP_PATTERN, 8'hFF, 1'b0);
		send_beat(OP_TEXT, 8'hFF, 1'b0);
		send_beat(OP_TEXT, 8'h00, 1'b0);
		send_beat(OP_TEXT, 8'hFF, 1'b0);
		// after a match the text is ignored, even across pattern growth
		send_beat(OP_TEXT, 8'h00, 1'b0);
		send_beat(OP_PATTERN, 8'h00, 1'b0);
		send_beat(OP_TEXT, 8'h12, 1'b0);
		// new text, then grow the pattern while partly matched
		send_beat(OP_TEXT, 8'h00, 1'b1);
		send_beat(OP_TEXT, 8'hFF, 1'b0);
		send_beat(OP_PATTERN, 8'h80, 1'b0);
		send_beat(OP_TEXT, 8'h00, 1'b0);
		send_beat(OP_TEXT, 8'h80, 1'b0);
		// new pattern clears the text state too
		send_beat(OP_PATTERN, 8'h55, 1'b1);
		send_beat(OP_TEXT, 8'h55, 1'b0);
		send_beat(OP_TEXT, 8'hAA, 1'b1);
		send_beat(OP_TEXT, 8'h55, 1'b0);
		wait_drained();
	endtask

	// full 64-byte pattern with deep link chains, bytes past capacity dropped
	task automatic test_full_pattern();
		sender_gaps_on = 1'b1;
		sink_stalls_on = 1'b1;
		for (int i = 0; i < MAX_PATTERN - 1; i++)
			send_beat(OP_PATTERN, 8'h61, i == 0);
		send_beat(OP_PATTERN, 8'h62, 1'b0);
		for (int i = 0; i < 3; i++)
			send_beat(OP_PATTERN, 8'h63, 1'b0);
		// long run of 'a' then a mismatch walks the whole chain back
		for (int i = 0; i < 40; i++)
			send_beat(OP_TEXT, 8'h61, i == 0);
		send_beat(OP_TEXT, 8'h63, 1'b0);
		for (int i = 0; i < 70; i++)
			send_beat(OP_TEXT, 8'h61, 1'b0);
		send_beat(OP_TEXT, 8'h62, 1'b0);
		send_beat(OP_TEXT, 8'h62, 1'b0);
		wait_drained();
	endtask

	// receiver holds off while the sender keeps offering text
	task automatic test_backpressure();
		sender_gaps_on = 1'b0;
		sink_stalls_on = 1'b0;
		send_beat(OP_PATTERN, 8'h3C, 1'b1);
		send_beat(OP_PATTERN, 8'hC3, 1'b0);
		sink_hold = 400;
		for (int i = 0; i < 24; i++)
			send_beat(OP_TEXT, ($urandom_range(0, 1) != 0) ? 8'h3C : 8'hC3, i == 0);
		wait_drained();
	endtask

	// random sequences: mostly pattern then text over a small alphabet
	task automatic test_random();
		logic [DATA_W-1:0] alpha [3];
		logic [DATA_W-1:0] pat   [MAX_PATTERN];
		int stop_at;
		int plen;
		int tlen;
		int at;
		int nsym;
		stop_at = pattern_beats + text_beats + RANDOM_BEATS;
		while (pattern_beats + text_beats < stop_at) begin
			sender_gaps_on = ($urandom_range(0, 4) != 0);
			sink_stalls_on = ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 4) == 0) begin
				// noise: any op, any byte, any first flag
				repeat ($urandom_range(1, 8))
					send_beat(1'($urandom_range(0, 1)), DATA_W'($urandom),
						1'($urandom_range(0, 1)));
			end else begin
				nsym = $urandom_range(2, 3);
				for (int i = 0; i < 3; i++)
					alpha[i] = DATA_W'($urandom);
				plen = ($urandom_range(0, 19) == 0) ? $urandom_range(10, MAX_PATTERN)
					: $urandom_range(1, 6);
				for (int i = 0; i < plen; i++) begin
					pat[i] = alpha[$urandom_range(0, nsym - 1)];
					send_beat(OP_PATTERN, pat[i], i == 0);
				end
				tlen = $urandom_range(4, 30);
				at   = ($urandom_range(0, 1) != 0) ? $urandom_range(0, tlen) : -1;
				for (int i = 0; i < tlen; i++) begin
					if (i == at) begin
						for (int j = 0; j < plen; j++)
							send_beat(OP_TEXT, pat[j], 1'b0);
					end
					if ($urandom_range(0, 19) == 0)
						send_beat(OP_PATTERN, alpha[$urandom_range(0, nsym - 1)], 1'b0);
					if ($urandom_range(0, 19) == 0)
						send_beat(OP_TEXT, DATA_W'($urandom), 1'b0);
					else
						send_beat(OP_TEXT, alpha[$urandom_range(0, nsym - 1)],
							i == 0 && $urandom_range(0, 7) != 0);
				end
			end
		end
		wait_drained();
	endtask

	initial begin : run_tests
		mismatches      = 0;
		reports_checked = 0;
		pattern_beats   = 0;
		text_beats      = 0;
		matches_seen    = 0;
		sender_gaps_on  = 1'b0;
		sink_stalls_on  = 1'b0;
		sink_hold       = 0;
		pat_len         = '0;
		build_k         = '0;
		clear_scan();
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_pattern();
		test_backpressure();
		test_random();

		repeat (SETTLE_TICKS) @(posedge clk);
		if (scan_reports_q.size() != 0) begin
			$error("%0d reports never arrived", scan_reports_q.size());
			mismatches++;
		end
		$display("covered %0d pattern beats and %0d text beats, %0d reports checked",
			pattern_beats, text_beats, reports_checked);
		$display("including %0d matched reports, pattern overflow and a long hold-off",
			matches_seen);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/kss_pkg.sv
rtl/kss_ram.sv
rtl/kss_walk.sv
rtl/kmp_substring_search_unit.sv
rtl/kss_checker.sv
sim/tb.sv
